// ===== hdl/fpa_pkg.sv =====
// fpa_pkg: shared types and action codes for the Q24.8 fixed-point ALU.
// No dependencies.
`timescale 1ns / 1ps
package fpa_pkg;

    typedef enum logic [3:0] {
        ACT_ADD      = 4'd0,
        ACT_SUB      = 4'd1,
        ACT_MUL      = 4'd2,
        ACT_DIV      = 4'd3,
        ACT_INC      = 4'd4,
        ACT_DEC      = 4'd5,
        ACT_MAX      = 4'd6,
        ACT_MIN      = 4'd7,
        ACT_TO_INT   = 4'd8,
        ACT_FROM_INT = 4'd9
    } action_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic [3:0]         action;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               a_greater;
        logic               a_less;
        logic               a_equal;
        logic [1:0]         status;
    } out_word_t;

endpackage

// ===== hdl/fpa_div_stage.sv =====
// fpa_div_stage: a few restoring-division steps of the pipelined divider.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
module fpa_div_stage #(
    parameter int NUM_BITS = 40,
    parameter int DEN_BITS = 32,
    parameter int STEPS    = 4
) (
    input  logic [DEN_BITS:0]   rem_in,
    input  logic [NUM_BITS-1:0] num_in,
    input  logic [DEN_BITS-1:0] den,
    output logic [DEN_BITS:0]   rem_out,
    output logic [NUM_BITS-1:0] num_out
);
    // Numerator shifts out its top bit; quotient bits shift in at bottom.
    always_comb
    begin
        logic [DEN_BITS+1:0] trial;
        logic [DEN_BITS:0]   r;
        logic [NUM_BITS-1:0] n;
        r = rem_in;
        n = num_in;
        for (int i = 0; i < STEPS; i++)
        begin
            trial = {r, n[NUM_BITS-1]} - {2'b00, den};
            if (!trial[DEN_BITS+1])
            begin
                r = trial[DEN_BITS:0];
                n = {n[NUM_BITS-2:0], 1'b1};
            end
            else
            begin
                r = {r[DEN_BITS-1:0], n[NUM_BITS-1]};
                n = {n[NUM_BITS-2:0], 1'b0};
            end
        end
        rem_out = r;
        num_out = n;
    end
endmodule

// ===== hdl/fixed_point_alu_q24_8.sv =====
// Fixed-point Q24.8 ALU top level, pipelined.
// Every action takes the same path through the pipe; throughput one word per cycle unless the output stalls.
// Depth set by the divider: 40 quotient bits, four per stage.
// A stall on the output freezes the whole pipe; ready is high whenever the
// last stage is empty or being taken. Reset clears all valid bits.
`timescale 1ns / 1ps
module fixed_point_alu_q24_8
    import fpa_pkg::*;
#(
    parameter int FRACTION_BITS = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_data
);
    localparam int W      = 32;
    localparam int NB     = W + FRACTION_BITS;
    localparam int STEPS  = 4;
    localparam int DSTG   = (NB + STEPS - 1) / STEPS;
    localparam int NBP    = DSTG * STEPS;
    localparam int LAT    = DSTG + 4;
    localparam logic [W-1:0] MAXPOS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINNEG = {1'b1, {(W-1){1'b0}}};

    // Side-band carried alongside the divider
    typedef struct packed {
        logic [3:0]   action;
        logic         neg;
        logic         gt;
        logic         lt;
        logic         eq;
        logic [W-1:0] quick;
        logic [1:0]   qstat;
        logic [W-1:0] mb;
    } side_t;

    logic advance;
    assign advance = !out_valid || out_ready;
    assign in_ready = advance;

    logic [LAT-1:0] vld_reg;
    assign out_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (advance)
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end

    // ---------------- stage 0: magnitudes, simple ops, compare
    logic [W-1:0] a, b, ma, mb, sum, dif, inc, dec;
    logic         na, nb, gt, lt, eq;
    logic [W-1:0] quick;
    logic [1:0]   qstat;
    always_comb
    begin
        a  = in_data.operand_a;
        b  = in_data.operand_b;
        na = a[W-1];
        nb = b[W-1];
        ma = na ? (~a + 1'b1) : a;
        mb = nb ? (~b + 1'b1) : b;
        gt = $signed(a) > $signed(b);
        lt = $signed(a) < $signed(b);
        eq = a == b;
        sum = a + b;
        dif = a - b;
        inc = a + 1'b1;
        dec = a - 1'b1;
        quick = '0;
        qstat = ST_OK;
        case (action_t'(in_data.action))
            ACT_ADD:
            begin
                quick = sum;
                if (na == nb && sum[W-1] != na)
                begin
                    quick = na ? MINNEG : MAXPOS;
                    qstat = ST_OVERFLOW;
                end
            end
            ACT_SUB:
            begin
                quick = dif;
                if (na != nb && dif[W-1] != na)
                begin
                    quick = na ? MINNEG : MAXPOS;
                    qstat = ST_OVERFLOW;
                end
            end
            ACT_INC:
            begin
                quick = inc;
                if (!na && inc[W-1])
                begin
                    quick = MAXPOS;
                    qstat = ST_OVERFLOW;
                end
            end
            ACT_DEC:
            begin
                quick = dec;
                if (na && !dec[W-1])
                begin
                    quick = MINNEG;
                    qstat = ST_OVERFLOW;
                end
            end
            ACT_MAX:    quick = gt ? a : b;
            ACT_MIN:    quick = gt ? b : a;
            ACT_TO_INT:
            begin
                quick = W'(ma >> FRACTION_BITS);
                if (na)
                    quick = ~quick + 1'b1;
            end
            ACT_FROM_INT:
            begin
                if ((ma >> (W - 1 - FRACTION_BITS)) != '0
                    && !(na && ma == (W'(1) << (W - 1 - FRACTION_BITS))))
                begin
                    quick = na ? MINNEG : MAXPOS;
                    qstat = ST_OVERFLOW;
                end
                else
                    quick = W'(a << FRACTION_BITS);
            end
            ACT_DIV:
                if (b == '0)
                    qstat = ST_DIV_ZERO;
            default: ;
        endcase
    end

    side_t        s0_reg;
    logic [W-1:0] ma0_reg, mb0_reg;
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_reg  <= '{in_data.action, na ^ nb, gt, lt, eq, quick, qstat, mb};
            ma0_reg <= ma;
            mb0_reg <= mb;
        end
    end

    // ---------------- stage 1: magnitude product (registered)
    logic [2*W-1:0] prod_reg;
    side_t          s1_reg;
    logic [W-1:0]   ma1_reg;
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg <= ma0_reg * mb0_reg;
            s1_reg   <= s0_reg;
            ma1_reg  <= ma0_reg;
        end
    end

    // ---------------- stage 2: round and saturate multiply
    logic [2*W-1:0] rnd;
    logic [W-1:0]   mres;
    logic [1:0]     mstat;
    always_comb
    begin
        rnd = (prod_reg + (64'(1) << (FRACTION_BITS - 1))) >> FRACTION_BITS;
        mstat = ST_OK;
        if (rnd > (s1_reg.neg ? {32'd0, MINNEG} : {32'd0, MAXPOS}))
        begin
            mres  = s1_reg.neg ? MINNEG : MAXPOS;
            mstat = ST_OVERFLOW;
        end
        else
            mres = s1_reg.neg ? (~rnd[W-1:0] + 1'b1) : rnd[W-1:0];
    end

    // Multiply result folded into the side-band
    side_t s1_fix;
    always_comb
    begin
        s1_fix = s1_reg;
        if (action_t'(s1_reg.action) == ACT_MUL)
        begin
            s1_fix.quick = mres;
            s1_fix.qstat = mstat;
        end
    end

    // ---------------- divider pipe
    logic [W:0]     rem_reg [DSTG+1];
    logic [NBP-1:0] num_reg [DSTG+1];
    side_t          sd_reg  [DSTG+1];
    logic [W:0]     rem_w   [DSTG];
    logic [NBP-1:0] num_w   [DSTG];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rem_reg[0] <= '0;
            num_reg[0] <= NBP'({ma1_reg, FRACTION_BITS'(0)});
            sd_reg[0]  <= s1_fix;
            for (int k = 0; k < DSTG; k++)
            begin
                rem_reg[k+1] <= rem_w[k];
                num_reg[k+1] <= num_w[k];
                sd_reg[k+1]  <= sd_reg[k];
            end
        end
    end

    for (genvar g = 0; g < DSTG; g++)
    begin : g_div
        fpa_div_stage #(.NUM_BITS(NBP), .DEN_BITS(W), .STEPS(STEPS)) u_stage (
            .rem_in  (rem_reg[g]),
            .num_in  (num_reg[g]),
            .den     (sd_reg[g].mb),
            .rem_out (rem_w[g]),
            .num_out (num_w[g])
        );
    end

    // ---------------- final stage: divide round/saturate, select
    side_t          sf;
    logic [NBP:0]   q;
    logic [W:0]     rm;
    logic [W-1:0]   dres, fres;
    logic [1:0]     dstat, fstat;
    always_comb
    begin
        sf = sd_reg[DSTG];
        rm = rem_reg[DSTG];
        q  = {1'b0, num_reg[DSTG]};
        if (rm >= ({1'b0, sf.mb} - rm))
            q = q + 1'b1;
        dstat = ST_OK;
        if (q > (sf.neg ? (NBP+1)'(MINNEG) : (NBP+1)'(MAXPOS)))
        begin
            dres  = sf.neg ? MINNEG : MAXPOS;
            dstat = ST_OVERFLOW;
        end
        else
            dres = sf.neg ? (~q[W-1:0] + 1'b1) : q[W-1:0];
        fres  = sf.quick;
        fstat = sf.qstat;
        if (action_t'(sf.action) == ACT_DIV && sf.qstat != ST_DIV_ZERO)
        begin
            fres  = dres;
            fstat = dstat;
        end
    end

    out_word_t out_reg;
    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= '{fres, sf.gt, sf.lt, sf.eq, fstat};
    end
    assign out_data = out_reg;

endmodule
